/* sv/jrh_pkg.sv */
// Shared constants, types and the helper function of the jet response histogrammer.
`default_nettype none

package jrh_pkg;

   // Histogram geometry
   localparam int RESPONSE_BINS = 40;
   localparam int PT_RANGES     = 13;
   localparam int JET_SLOTS     = 3;
   localparam int BIN_SPAN      = RESPONSE_BINS + 2;
   localparam int STORE_DEPTH   = JET_SLOTS * PT_RANGES * BIN_SPAN;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   // Field widths
   localparam int PT_W     = 16;
   localparam int ANG_W    = 16;
   localparam int SLOT_W   = 2;
   localparam int RANGE_W  = 4;
   localparam int BIN_W    = 6;
   localparam int COUNT_W  = 32;
   localparam int RADIUS_W = 20;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_RADIUS = '0;
   localparam logic [RADIUS_W-1:0]  RADIUS_RESET     = 20'd41943;

   // Arithmetic widths
   localparam int DIFF_W = ANG_W + 1;          // angle difference
   localparam int SQ_W   = 2 * DIFF_W - 1;     // square of a difference
   localparam int DSQ_W  = SQ_W + 1;           // sum of two squares
   localparam int NUM_W  = PT_W + 4;           // 5*reco - 4*gen, signed
   localparam int DEN_W  = PT_W + 1;           // 2*gen
   localparam int QUOT_W = $clog2(RESPONSE_BINS);
   localparam int STEP_W = $clog2(QUOT_W + 1);
   localparam int REM_W  = DEN_W + QUOT_W;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int OUT_W       = $clog2(QUEUE_DEPTH + 1);

   // Lower pt edges of the ranges, 0.25 GeV units
   localparam logic [PT_W-1:0] RANGE_LOW_EDGE [13] = '{
      16'd200, 16'd320, 16'd480, 16'd680, 16'd1200, 16'd1880, 16'd2400,
      16'd3200, 16'd4000, 16'd5600, 16'd7200, 16'd9600, 16'd12800
   };

   typedef enum logic {
      OP_FILL = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // One classified request as passed from front to back
   typedef struct packed {
      logic                is_read;
      logic                do_mem;
      logic                need_div;
      logic [RANGE_W-1:0]  range_idx;
      logic [BIN_W-1:0]    bin_idx;
      logic [ADDR_W-1:0]   base;
      logic [REM_W-1:0]    dividend;
      logic [DEN_W-1:0]    divisor;
   } job_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_DIV,
      BK_READ,
      BK_WAIT
   } back_state_type;

   // Highest range whose lower edge pt reaches; MSB flags a valid range
   function automatic logic [RANGE_W:0] find_range(input logic [PT_W-1:0] pt);
      logic                ok;
      logic [RANGE_W-1:0]  idx;
      ok  = 1'b0;
      idx = '0;
      for (int r = 0; r < PT_RANGES; r++) begin
         if (pt >= RANGE_LOW_EDGE[r]) begin
            ok  = 1'b1;
            idx = RANGE_W'(r);
         end
      end
      return {ok, idx};
   endfunction

endpackage

`default_nettype wire

/* sv/jrh_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module jrh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/jrh_front.sv */
// Front end: takes requests, matches the jet pair, finds pt ranges and classifies the bin.
`default_nettype none

module jrh_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         operation,
   input  logic [jrh_pkg::SLOT_W-1:0]   jet_slot,
   input  logic [jrh_pkg::PT_W-1:0]     reco_pt,
   input  logic [jrh_pkg::PT_W-1:0]     gen_pt,
   input  logic [jrh_pkg::ANG_W-1:0]    reco_eta,
   input  logic [jrh_pkg::ANG_W-1:0]    gen_eta,
   input  logic [jrh_pkg::ANG_W-1:0]    reco_phi,
   input  logic [jrh_pkg::ANG_W-1:0]    gen_phi,
   input  logic [jrh_pkg::RANGE_W-1:0]  read_range,
   input  logic [jrh_pkg::BIN_W-1:0]    read_bin,
   input  logic [jrh_pkg::RADIUS_W-1:0] radius,
   output logic                         push,
   output jrh_pkg::job_type             job
);

   import jrh_pkg::*;

   typedef struct packed {
      op_type                    op;
      logic [SLOT_W-1:0]         slot;
      logic [PT_W-1:0]           reco_pt;
      logic [PT_W-1:0]           gen_pt;
      logic signed [DIFF_W-1:0]  deta;
      logic signed [DIFF_W-1:0]  dphi;
      logic [RANGE_W-1:0]        read_range;
      logic [BIN_W-1:0]          read_bin;
   } stage1_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [RANGE_W-1:0]  read_range;
      logic [BIN_W-1:0]    read_bin;
      logic [SQ_W-1:0]     sq_eta;
      logic [SQ_W-1:0]     sq_phi;
      logic [RANGE_W:0]    reco_rng;
      logic [RANGE_W:0]    gen_rng;
      logic [NUM_W-1:0]    num;
      logic [DEN_W-1:0]    den;
   } stage2_type;

   logic       v1_ff, v2_ff;
   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;

   logic signed [2*DIFF_W-1:0] prod_eta, prod_phi;

   logic [DSQ_W-1:0]   dsq;
   logic               match, is_read, fill_ok, read_ok;
   logic               num_neg, num_big;
   logic [RANGE_W-1:0] rng_sel;

   // Stage 1: register the request with the angle differences
   always_comb begin
      s1_in.op         = op_type'(operation);
      s1_in.slot       = jet_slot;
      s1_in.reco_pt    = reco_pt;
      s1_in.gen_pt     = gen_pt;
      s1_in.deta       = $signed({reco_eta[ANG_W-1], reco_eta})
                       - $signed({gen_eta[ANG_W-1], gen_eta});
      s1_in.dphi       = $signed({reco_phi[ANG_W-1], reco_phi})
                       - $signed({gen_phi[ANG_W-1], gen_phi});
      s1_in.read_range = read_range;
      s1_in.read_bin   = read_bin;
   end

   // Stage 2: squares, pt ranges, response numerator and denominator
   assign prod_eta = s1_ff.deta * s1_ff.deta;
   assign prod_phi = s1_ff.dphi * s1_ff.dphi;

   always_comb begin
      s2_in.op         = s1_ff.op;
      s2_in.slot       = s1_ff.slot;
      s2_in.read_range = s1_ff.read_range;
      s2_in.read_bin   = s1_ff.read_bin;
      s2_in.sq_eta     = prod_eta[SQ_W-1:0];
      s2_in.sq_phi     = prod_phi[SQ_W-1:0];
      s2_in.reco_rng   = find_range(s1_ff.reco_pt);
      s2_in.gen_rng    = find_range(s1_ff.gen_pt);
      // 5*reco - 4*gen in two's complement
      s2_in.num        = NUM_W'({s1_ff.reco_pt, 2'b00}) + NUM_W'(s1_ff.reco_pt)
                       - NUM_W'({s1_ff.gen_pt, 2'b00});
      s2_in.den        = {s1_ff.gen_pt, 1'b0};
   end

   // Stage 3: match decision and job build, pushed into the queue
   always_comb begin
      dsq     = DSQ_W'(s2_ff.sq_eta) + DSQ_W'(s2_ff.sq_phi);
      match   = dsq < DSQ_W'(radius);
      is_read = (s2_ff.op == OP_READ);
      fill_ok = (int'(s2_ff.slot) < JET_SLOTS) && match
             && s2_ff.reco_rng[RANGE_W] && s2_ff.gen_rng[RANGE_W]
             && (s2_ff.reco_rng[RANGE_W-1:0] == s2_ff.gen_rng[RANGE_W-1:0]);
      read_ok = (int'(s2_ff.slot) < JET_SLOTS)
             && (int'(s2_ff.read_range) < PT_RANGES)
             && (int'(s2_ff.read_bin) < BIN_SPAN);
      num_neg = s2_ff.num[NUM_W-1];
      num_big = !num_neg && (s2_ff.num >= NUM_W'(s2_ff.den));
      rng_sel = is_read ? s2_ff.read_range : s2_ff.reco_rng[RANGE_W-1:0];

      job.is_read  = is_read;
      job.do_mem   = is_read ? read_ok : fill_ok;
      job.need_div = !is_read && !num_neg && !num_big;
      job.base     = (ADDR_W'(s2_ff.slot) * ADDR_W'(PT_RANGES) + ADDR_W'(rng_sel))
                   * ADDR_W'(BIN_SPAN);
      job.dividend = REM_W'(s2_ff.num[DEN_W-1:0]) * REM_W'(RESPONSE_BINS);
      job.divisor  = s2_ff.den;
      if (is_read) begin
         job.range_idx = s2_ff.read_range;
         job.bin_idx   = s2_ff.read_bin;
      end else if (!fill_ok) begin
         job.range_idx = '0;
         job.bin_idx   = '0;
      end else begin
         job.range_idx = rng_sel;
         // underflow or overflow settles the bin here; otherwise the back divides
         job.bin_idx   = num_neg ? BIN_W'(0) : BIN_W'(RESPONSE_BINS + 1);
      end
   end

   assign push = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

`default_nettype wire

/* sv/jrh_queue.sv */
// Short job queue between the front end and the back end.
`default_nettype none

module jrh_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jrh_pkg::job_type push_job,
   input  logic             pop,
   output jrh_pkg::job_type head_job,
   output logic             empty
);

   import jrh_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [OUT_W-1:0]    cnt_ff, cnt_in;

   // Pointer and fill count update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         tail_in = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         entry_ff[tail_ff] <= push_job;
      end
   end

   assign head_job = entry_ff[head_ff];
   assign empty    = (cnt_ff == '0);

endmodule

`default_nettype wire

/* sv/jrh_back.sv */
// Back end: serial bin divider, counter store read-modify-write and result register.
`default_nettype none

module jrh_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  jrh_pkg::job_type             q_job,
   output logic                         q_pop,
   output logic                         clearing,
   output logic                         rsp_valid,
   output logic                         rsp_filled,
   output logic [jrh_pkg::RANGE_W-1:0]  rsp_range_index,
   output logic [jrh_pkg::BIN_W-1:0]    rsp_bin_index,
   output logic [jrh_pkg::COUNT_W-1:0]  rsp_count
);

   import jrh_pkg::*;

   back_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   job_type             job_ff, job_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    dsr_ff, dsr_in;
   logic [QUOT_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [BIN_W-1:0]    bin_ff, bin_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_filled_ff, rsp_filled_in;
   logic [RANGE_W-1:0]  rsp_range_ff, rsp_range_in;
   logic [BIN_W-1:0]    rsp_bin_ff, rsp_bin_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [COUNT_W-1:0]  wr_data, rd_data, count_inc;
   logic [REM_W:0]      trial;
   logic [QUOT_W-1:0]   quo_next;

   jrh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Divider step: subtract the shifted divisor where it fits
   assign trial    = {1'b0, rem_ff} - {1'b0, dsr_ff};
   assign quo_next = QUOT_W'({quo_ff, ~trial[REM_W]});

   // Saturating increment
   assign count_inc = (rd_data == '1) ? rd_data : rd_data + 1'b1;

   assign rd_addr = job_ff.base + ADDR_W'(bin_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty && q_job.do_mem) begin
               state_in = q_job.need_div ? BK_DIV : BK_READ;
            end
         end
         BK_DIV: begin
            if (step_ff == '0) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_WAIT;
         end
         BK_WAIT: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = rd_addr;
      wr_data       = count_inc;
      rd_en         = 1'b0;
      clr_in        = clr_ff;
      job_in        = job_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      bin_in        = bin_ff;
      rsp_valid_in  = 1'b0;
      rsp_filled_in = rsp_filled_ff;
      rsp_range_in  = rsp_range_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               job_in  = q_job;
               rem_in  = q_job.dividend;
               dsr_in  = REM_W'(q_job.divisor) << (QUOT_W - 1);
               quo_in  = '0;
               step_in = STEP_W'(QUOT_W - 1);
               bin_in  = q_job.bin_idx;
               // nothing to count or read: answer right away
               if (!q_job.do_mem) begin
                  rsp_valid_in  = 1'b1;
                  rsp_filled_in = 1'b0;
                  rsp_range_in  = q_job.range_idx;
                  rsp_bin_in    = q_job.bin_idx;
                  rsp_count_in  = '0;
               end
            end
         end
         BK_DIV: begin
            if (!trial[REM_W]) begin
               rem_in = trial[REM_W-1:0];
            end
            dsr_in  = dsr_ff >> 1;
            quo_in  = quo_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               bin_in = BIN_W'(quo_next) + BIN_W'(1);
            end
         end
         BK_READ: begin
            rd_en = 1'b1;
         end
         BK_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_filled_in = !job_ff.is_read;
            rsp_range_in  = job_ff.range_idx;
            rsp_bin_in    = bin_ff;
            if (job_ff.is_read) begin
               rsp_count_in = rd_data;
            end else begin
               wr_en        = 1'b1;
               rsp_count_in = count_inc;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff        <= job_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      bin_ff        <= bin_in;
      rsp_filled_ff <= rsp_filled_in;
      rsp_range_ff  <= rsp_range_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign clearing        = (state_ff == BK_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filled      = rsp_filled_ff;
   assign rsp_range_index = rsp_range_ff;
   assign rsp_bin_index   = rsp_bin_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

`default_nettype wire

/* sv/jet_response_histogrammer.sv */
// Top level of the jet response histogrammer: config register, request credit, front/queue/back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   request  | start, busy               | req_operation .. req_read_bin
//   result   | rsp_valid (one cycle)     | rsp_filled, rsp_range_index, rsp_bin_index,
//            |                           | rsp_count
//   config   | psel, penable, pwrite,    | paddr, pwdata, prdata (match_radius_sq at 0)
//            | pready                    |
//
// A request passes the front-end pipeline registers and then waits in a four-entry queue.
// The back end takes one job at a time: a job with nothing to count or read (a fill that
// does not qualify or an out-of-range read) answers straight from idle, a read or an
// under/overflow fill passes the store read and wait states (store read, then write on a fill),
// and an in-range fill first runs the bit-serial bin divider; these states set the job rate.
// After reset busy stays high while all 1638 counter store words are cleared.
// busy also rises when four requests are in flight ahead of the back end.
// Results cannot be stalled by the receiver.
`default_nettype none

module jet_response_histogrammer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_operation,
   input  logic [jrh_pkg::SLOT_W-1:0]      req_jet_slot,
   input  logic [jrh_pkg::PT_W-1:0]        req_reco_pt,
   input  logic [jrh_pkg::PT_W-1:0]        req_gen_pt,
   input  logic signed [jrh_pkg::ANG_W-1:0] req_reco_eta,
   input  logic signed [jrh_pkg::ANG_W-1:0] req_gen_eta,
   input  logic signed [jrh_pkg::ANG_W-1:0] req_reco_phi,
   input  logic signed [jrh_pkg::ANG_W-1:0] req_gen_phi,
   input  logic [jrh_pkg::RANGE_W-1:0]     req_read_range,
   input  logic [jrh_pkg::BIN_W-1:0]       req_read_bin,
   output logic                            rsp_valid,
   output logic                            rsp_filled,
   output logic [jrh_pkg::RANGE_W-1:0]     rsp_range_index,
   output logic [jrh_pkg::BIN_W-1:0]       rsp_bin_index,
   output logic [jrh_pkg::COUNT_W-1:0]     rsp_count,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [jrh_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [jrh_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [jrh_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   import jrh_pkg::*;

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [OUT_W-1:0]    inflight_ff, inflight_in;
   logic                accept, clearing, push, pop, q_empty, csr_hit;
   job_type             push_job, head_job;

   // Configuration register
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_MATCH_RADIUS);
   assign prdata  = csr_hit ? CSR_DATA_W'(radius_ff) : '0;

   always_comb begin
      radius_in = radius_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         radius_in = pwdata[RADIUS_W-1:0];
      end
   end

   // Requests in the front end or queue; never more than the queue holds
   assign busy   = clearing || (inflight_ff == OUT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      inflight_in = inflight_ff;
      if (accept && !pop) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (pop && !accept) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RADIUS_RESET;
         inflight_ff <= '0;
      end else begin
         radius_ff   <= radius_in;
         inflight_ff <= inflight_in;
      end
   end

   jrh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_operation),
      .jet_slot   (req_jet_slot),
      .reco_pt    (req_reco_pt),
      .gen_pt     (req_gen_pt),
      .reco_eta   (req_reco_eta),
      .gen_eta    (req_gen_eta),
      .reco_phi   (req_reco_phi),
      .gen_phi    (req_gen_phi),
      .read_range (req_read_range),
      .read_bin   (req_read_bin),
      .radius     (radius_ff),
      .push       (push),
      .job        (push_job)
   );

   jrh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   jrh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_job           (head_job),
      .q_pop           (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_filled      (rsp_filled),
      .rsp_range_index (rsp_range_index),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_count       (rsp_count)
   );

endmodule

`default_nettype wire
